// File: src/tpfc_pkg.sv
// ----------------------------------------------------------------------------
// tpfc_pkg
// Types and constants shared by the tcp port frame classifier files.
// ----------------------------------------------------------------------------
package tpfc_pkg;

  // frame layout
  localparam logic [6:0]  POS_ETYPE_HI   = 7'd12;
  localparam logic [6:0]  POS_ETYPE_LO   = 7'd13;
  localparam logic [6:0]  POS_IHL        = 7'd14;
  localparam logic [6:0]  POS_PROTO      = 7'd23;
  localparam logic [6:0]  POS_SRC_FIRST  = 7'd26;
  localparam logic [6:0]  POS_SRC_LAST   = 7'd29;
  localparam logic [6:0]  POS_DST_FIRST  = 7'd30;
  localparam logic [6:0]  POS_DST_LAST   = 7'd33;
  // ethernet header plus the two tcp source port bytes
  localparam logic [6:0]  PORT_POS_BASE  = 7'd16;
  localparam logic [6:0]  COUNT_MAX      = 7'd127;

  localparam logic [7:0]  ETH_HDR_LEN    = 8'd14;
  localparam logic [7:0]  IP_MIN_END     = 8'd34;
  // ethernet header plus tcp header
  localparam logic [7:0]  TCP_END_BASE   = 8'd34;

  localparam logic [15:0] ETHERTYPE_IPV4 = 16'h0800;
  localparam logic [7:0]  PROTO_TCP      = 8'd6;
  localparam logic [15:0] DEFAULT_PORT   = 16'd80;

  // configuration port
  localparam int unsigned CFG_ADDR_W     = 3;
  localparam logic        REG_MATCH_PORT = 1'b0;

  localparam int unsigned OUT_DATA_W     = 72;
  localparam int unsigned OUT_USED_W     = 66;

  typedef enum logic [1:0] {
    VERDICT_PASS  = 2'd0,
    VERDICT_ABORT = 2'd1,
    VERDICT_MATCH = 2'd2
  } verdict_t;

  typedef struct packed {
    logic [31:0] dest_address;
    logic [31:0] source_address;
    verdict_t    verdict;
  } result_t;

endpackage

// File: src/tpfc_parser.sv
// ----------------------------------------------------------------------------
// tpfc_parser
// Per-frame byte counter, header field captures and the verdict logic.
// ----------------------------------------------------------------------------
module tpfc_parser
  import tpfc_pkg::*;
(
  input  logic        clk,
  input  logic        rst_n,
  input  logic        step,
  input  logic [7:0]  frame_byte,
  input  logic        last_byte,
  input  logic [15:0] match_port,
  output result_t     result
);

  logic [6:0]  count_r,  count_nxt;
  logic [15:0] etype_r,  etype_nxt;
  logic [3:0]  hw_r,     hw_nxt;
  logic [7:0]  proto_r,  proto_nxt;
  logic [31:0] src_r,    src_nxt;
  logic [31:0] dst_r,    dst_nxt;
  logic [15:0] port_r,   port_nxt;

  logic [6:0]  port_pos;
  logic        port_hit;
  logic [7:0]  frame_len;
  logic [7:0]  tcp_end;

  // ihl is fixed from byte 14 on, and the port never lies before byte 16
  assign port_pos = PORT_POS_BASE + {1'b0, hw_r, 2'b00};
  assign port_hit = (count_r > POS_IHL) && (count_r[6:1] == port_pos[6:1]);

  always_comb begin
    etype_nxt = etype_r;
    hw_nxt    = hw_r;
    proto_nxt = proto_r;
    src_nxt   = src_r;
    dst_nxt   = dst_r;
    port_nxt  = port_r;
    if (count_r == POS_ETYPE_HI || count_r == POS_ETYPE_LO) begin
      etype_nxt = {etype_r[7:0], frame_byte};
    end
    if (count_r == POS_IHL) begin
      hw_nxt = frame_byte[3:0];
    end
    if (count_r == POS_PROTO) begin
      proto_nxt = frame_byte;
    end
    if (count_r >= POS_SRC_FIRST && count_r <= POS_SRC_LAST) begin
      src_nxt = {src_r[23:0], frame_byte};
    end
    if (count_r >= POS_DST_FIRST && count_r <= POS_DST_LAST) begin
      dst_nxt = {dst_r[23:0], frame_byte};
    end
    if (port_hit) begin
      port_nxt = {port_r[7:0], frame_byte};
    end
  end

  always_comb begin
    if (last_byte) begin
      count_nxt = '0;
    end else if (count_r == COUNT_MAX) begin
      count_nxt = count_r;
    end else begin
      count_nxt = count_r + 7'd1;
    end
  end

  // frame length includes the byte on hand
  assign frame_len = {1'b0, count_r} + 8'd1;
  assign tcp_end   = TCP_END_BASE + {2'b00, hw_nxt, 2'b00};

  always_comb begin
    result.source_address = '0;
    result.dest_address   = '0;
    if (frame_len < ETH_HDR_LEN) begin
      result.verdict = VERDICT_ABORT;
    end else if (etype_nxt != ETHERTYPE_IPV4) begin
      result.verdict = VERDICT_PASS;
    end else if (frame_len < IP_MIN_END) begin
      result.verdict = VERDICT_ABORT;
    end else if (proto_nxt != PROTO_TCP) begin
      result.verdict = VERDICT_PASS;
    end else if (frame_len < tcp_end) begin
      result.verdict = VERDICT_ABORT;
    end else if (port_nxt != match_port) begin
      result.verdict = VERDICT_PASS;
    end else begin
      result.verdict        = VERDICT_MATCH;
      result.source_address = src_nxt;
      result.dest_address   = dst_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      count_r <= '0;
    end else if (step) begin
      count_r <= count_nxt;
    end
  end

  // captures are always rewritten before the verdict looks at them
  always_ff @(posedge clk) begin
    if (step) begin
      etype_r <= etype_nxt;
      hw_r    <= hw_nxt;
      proto_r <= proto_nxt;
      src_r   <= src_nxt;
      dst_r   <= dst_nxt;
      port_r  <= port_nxt;
    end
  end

endmodule

// File: src/tcp_port_frame_classifier_core.sv
// ----------------------------------------------------------------------------
// tcp_port_frame_classifier_core
// Classifies ethernet frames by ipv4/tcp destination port, one byte per cycle unless a last byte waits.
// ----------------------------------------------------------------------------
// a byte taken is held in byte_r and parsed from there; a verdict is registered
//   into res_r and out_tvalid when its last byte advances out of byte_r
// throughput: one byte per cycle, set by the single capture and verdict pass;
//   only a last byte waits while an earlier verdict is still held
// reset: synchronous on rst_n low; match_port returns to 80, the byte counter
//   and both stage valids clear
module tcp_port_frame_classifier_core
  import tpfc_pkg::*;
(
  input  logic                  clk,
  input  logic                  rst_n,
  // input stream
  input  logic                  in_tvalid,
  output logic                  in_tready,
  input  logic [7:0]            in_tdata,   // [7:0] frame_byte
  input  logic                  in_tlast,   // last_byte
  // result stream
  output logic                  out_tvalid,
  input  logic                  out_tready,
  output logic [OUT_DATA_W-1:0] out_tdata,  // [1:0] verdict, [33:2] source_address,
                                            // [65:34] dest_address, [71:66] zero
  // configuration
  input  logic                  cfg_psel,
  input  logic                  cfg_penable,
  input  logic                  cfg_pwrite,
  input  logic [CFG_ADDR_W-1:0] cfg_paddr,
  input  logic [31:0]           cfg_pwdata,
  output logic [31:0]           cfg_prdata,
  output logic                  cfg_pready
);

  logic        in_valid_r;
  logic [7:0]  byte_r;
  logic        last_r;
  logic        out_valid_r;
  result_t     res_r;
  result_t     res_nxt;
  logic [15:0] match_port_r;
  logic        advance;
  logic        cfg_wr;

  // configuration register
  assign cfg_pready = 1'b1;
  assign cfg_wr     = cfg_psel & cfg_penable & cfg_pwrite & cfg_pready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      match_port_r <= DEFAULT_PORT;
    end else if (cfg_wr && cfg_paddr[2] == REG_MATCH_PORT) begin
      match_port_r <= cfg_pwdata[15:0];
    end
  end

  always_comb begin
    if (cfg_paddr[2] == REG_MATCH_PORT) begin
      cfg_prdata = {16'h0000, match_port_r};
    end else begin
      cfg_prdata = '0;
    end
  end

  // a non-final byte never needs the output register
  assign advance   = in_valid_r & (~last_r | ~out_valid_r | out_tready);
  assign in_tready = ~in_valid_r | advance;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_valid_r <= 1'b0;
    end else if (in_tready) begin
      in_valid_r <= in_tvalid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_tready && in_tvalid) begin
      byte_r <= in_tdata;
      last_r <= in_tlast;
    end
  end

  tpfc_parser u_parser (
    .clk        (clk),
    .rst_n      (rst_n),
    .step       (advance),
    .frame_byte (byte_r),
    .last_byte  (last_r),
    .match_port (match_port_r),
    .result     (res_nxt)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (advance && last_r) begin
      out_valid_r <= 1'b1;
    end else if (out_tready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (advance && last_r) begin
      res_r <= res_nxt;
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = {{(OUT_DATA_W - OUT_USED_W){1'b0}}, res_r};

endmodule

// File: src/tpfc_checker.sv
// ----------------------------------------------------------------------------
// tpfc_checker
// Port-level checks on the classifier result stream.
// ----------------------------------------------------------------------------
module tpfc_checker
  import tpfc_pkg::*;
(
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  out_tvalid,
  input  logic                  out_tready,
  input  logic [OUT_DATA_W-1:0] out_tdata
);

  // a stalled transaction holds
  assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tready |=> out_tvalid && $stable(out_tdata))
    else $error("result transaction changed while stalled");

  // no verdict right after reset
  assert property (@(posedge clk) !rst_n |=> !out_tvalid)
    else $error("result valid after reset");

  assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid |-> out_tdata[1:0] <= VERDICT_MATCH)
    else $error("undefined verdict code");

  // addresses only travel with a match
  assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && out_tdata[1:0] != VERDICT_MATCH |-> out_tdata[OUT_DATA_W-1:2] == '0)
    else $error("addresses set on a non-matched verdict");

endmodule

bind tcp_port_frame_classifier_core tpfc_checker u_tpfc_checker (
  .clk        (clk),
  .rst_n      (rst_n),
  .out_tvalid (out_tvalid),
  .out_tready (out_tready),
  .out_tdata  (out_tdata)
);
